// File: rtl/gpio_pin_controller_assert.svh
// Assertion macros shared by the GPIO pin controller RTL.
`ifndef GPIO_PIN_CONTROLLER_ASSERT_SVH
`define GPIO_PIN_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define GPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gpio_pin_controller: assertion failed");

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define GPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gpio_pin_controller: assertion failed");

`endif

// File: rtl/gpc_pkg.sv
// Package for the GPIO pin controller: payload types, commands and register offsets.
`default_nettype none

package gpc_pkg;

  // Payload field types.
  typedef logic [2:0]  cmd_t;
  typedef logic [6:0]  ofs_t;
  typedef logic [31:0] word_t;
  typedef logic [4:0]  pin_t;

  // Default pin count.
  localparam int NUM_PINS_DEF = 32;

  // Command codes.
  localparam cmd_t CMD_READ  = 3'd0;
  localparam cmd_t CMD_WRITE = 3'd1;
  localparam cmd_t CMD_PAD   = 3'd2;
  localparam cmd_t CMD_PER_A = 3'd3;
  localparam cmd_t CMD_PER_B = 3'd4;

  // Register word offsets (byte offset divided by four).
  localparam ofs_t OFS_OWN_SET   = 7'h00;
  localparam ofs_t OFS_OWN_CLR   = 7'h01;
  localparam ofs_t OFS_OWN_RD    = 7'h02;
  localparam ofs_t OFS_OE_SET    = 7'h04;
  localparam ofs_t OFS_OE_CLR    = 7'h05;
  localparam ofs_t OFS_OE_RD     = 7'h06;
  localparam ofs_t OFS_FLT_SET   = 7'h08;
  localparam ofs_t OFS_FLT_CLR   = 7'h09;
  localparam ofs_t OFS_FLT_RD    = 7'h0A;
  localparam ofs_t OFS_ODATA_SET = 7'h0C;
  localparam ofs_t OFS_ODATA_CLR = 7'h0D;
  localparam ofs_t OFS_ODATA     = 7'h0E;
  localparam ofs_t OFS_PDATA_RD  = 7'h0F;
  localparam ofs_t OFS_IMASK_SET = 7'h10;
  localparam ofs_t OFS_IMASK_CLR = 7'h11;
  localparam ofs_t OFS_IMASK_RD  = 7'h12;
  localparam ofs_t OFS_ISTAT_RD  = 7'h13;
  localparam ofs_t OFS_MD_SET    = 7'h14;
  localparam ofs_t OFS_MD_CLR    = 7'h15;
  localparam ofs_t OFS_MD_RD     = 7'h16;
  localparam ofs_t OFS_PU_DIS    = 7'h18;
  localparam ofs_t OFS_PU_EN     = 7'h19;
  localparam ofs_t OFS_PU_RD     = 7'h1A;
  localparam ofs_t OFS_PB_CLR    = 7'h1C;
  localparam ofs_t OFS_PB_SET    = 7'h1D;
  localparam ofs_t OFS_PB_RD     = 7'h1E;
  localparam ofs_t OFS_WE_SET    = 7'h28;
  localparam ofs_t OFS_WE_CLR    = 7'h29;
  localparam ofs_t OFS_WE_RD     = 7'h2A;

endpackage

`default_nettype wire

// File: rtl/gpc_if.sv
// Valid/ready channel interfaces for the GPIO pin controller's input and result beats.
`default_nettype none

interface gpc_in_if;
  logic           valid;
  logic           ready;
  gpc_pkg::cmd_t  cmd;
  gpc_pkg::ofs_t  word_offset;
  gpc_pkg::word_t write_data;
  gpc_pkg::pin_t  pin_index;
  logic           pin_level;

  modport source (output valid, cmd, word_offset, write_data, pin_index, pin_level,
                  input ready);
  modport sink (input valid, cmd, word_offset, write_data, pin_index, pin_level,
                output ready);
endinterface

interface gpc_out_if;
  logic           valid;
  logic           ready;
  gpc_pkg::word_t read_data;
  gpc_pkg::word_t pad_levels;
  logic           irq_out;
  logic           levels_changed;
  logic           bad_access;

  modport source (output valid, read_data, pad_levels, irq_out, levels_changed, bad_access,
                  input ready);
  modport sink (input valid, read_data, pad_levels, irq_out, levels_changed, bad_access,
                output ready);
endinterface

`default_nettype wire

// File: rtl/gpio_pin_controller.sv
// GPIO pin controller top level: register file, pin multiplexer and interrupt status.
//
// Usage: each input beat on in_chan is a bus read, a bus write, or a level change
// on a pad, peripheral A or peripheral B line. Every accepted beat yields exactly
// one result beat on out_chan carrying read data, the pin levels after the beat,
// the interrupt line, a level-change flag and an illegal-offset flag.
// A beat accepted on in_chan is captured in the input register and then in the
// result register, which drives out_chan. Throughput is one beat per cycle while
// the receiver does not stall: the two registers form a two-stage pipeline, and
// all per-pin work is parallel bitwise logic between them.
// A stalled receiver holds the result register; the input register still takes
// one more beat, after which in_chan.ready drops until out_chan.ready returns.
// Reset (rst_n low, synchronous) clears both valid flags and every control and
// status register, so all pins read low and no interrupt is pending.
`default_nettype none

module gpio_pin_controller #(
  parameter int NUM_PINS = gpc_pkg::NUM_PINS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  gpc_in_if.sink      in_chan,
  gpc_out_if.source   out_chan
);

  `include "gpio_pin_controller_assert.svh"

  localparam logic [5:0] PIN_LIMIT = 6'(NUM_PINS);

  typedef logic [NUM_PINS-1:0] pins_t;

  // Handshake and pipeline valid flags.
  logic s0_valid_r, s0_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free, adv, in_fire;

  // Input register payload.
  gpc_pkg::cmd_t  s0_cmd_r;
  gpc_pkg::ofs_t  s0_ofs_r;
  gpc_pkg::word_t s0_wdata_r;
  gpc_pkg::pin_t  s0_pin_r;
  logic           s0_level_r;

  // Result register payload.
  gpc_pkg::word_t out_rdata_r, out_rdata_nxt;
  gpc_pkg::word_t out_pad_r, out_pad_nxt;
  logic           out_irq_r, out_irq_nxt;
  logic           out_chg_r, out_chg_nxt;
  logic           out_bad_r, out_bad_nxt;

  // Controller state.
  pins_t own_r, own_nxt;
  pins_t oe_r, oe_nxt;
  pins_t flt_r, flt_nxt;
  pins_t odata_r, odata_nxt;
  pins_t pin_data_r, pin_data_nxt;
  pins_t imask_r, imask_nxt;
  pins_t istat_r, istat_nxt;
  pins_t md_r, md_nxt;
  pins_t pu_dis_r, pu_dis_nxt;
  pins_t pb_sel_r, pb_sel_nxt;
  pins_t we_r, we_nxt;
  pins_t pad_lvl_r, pad_lvl_nxt;
  pins_t pa_lvl_r, pa_lvl_nxt;
  pins_t pb_lvl_r, pb_lvl_nxt;

  // Combinational helpers.
  pins_t          wdata;
  pins_t          pin_bit;
  logic [31:0]    pin_onehot;
  logic           pin_ok;
  logic           recompute;
  pins_t          istat_cleared;
  pins_t          own_levels;
  pins_t          per_levels;
  logic           is_stat_rd;

  // Pipeline handshake: the input stage moves on when the result register is free.
  assign out_free      = !out_valid_r || out_chan.ready;
  assign adv           = s0_valid_r && out_free;
  assign in_chan.ready = !s0_valid_r || adv;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_comb begin
    s0_valid_nxt  = in_fire ? 1'b1 : (adv ? 1'b0 : s0_valid_r);
    out_valid_nxt = adv ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
  end

  // Decode and register update for the beat in the input register.
  always_comb begin
    own_nxt       = own_r;
    oe_nxt        = oe_r;
    flt_nxt       = flt_r;
    odata_nxt     = odata_r;
    imask_nxt     = imask_r;
    istat_cleared = istat_r;
    md_nxt        = md_r;
    pu_dis_nxt    = pu_dis_r;
    pb_sel_nxt    = pb_sel_r;
    we_nxt        = we_r;
    pad_lvl_nxt   = pad_lvl_r;
    pa_lvl_nxt    = pa_lvl_r;
    pb_lvl_nxt    = pb_lvl_r;
    out_rdata_nxt = '0;
    out_bad_nxt   = 1'b0;
    recompute     = 1'b0;
    wdata         = s0_wdata_r[NUM_PINS-1:0];
    pin_onehot    = 32'd1 << s0_pin_r;
    pin_bit       = pin_onehot[NUM_PINS-1:0];
    pin_ok        = {1'b0, s0_pin_r} < PIN_LIMIT;
    case (s0_cmd_r)
      gpc_pkg::CMD_READ: begin
        case (s0_ofs_r)
          gpc_pkg::OFS_OWN_RD:   out_rdata_nxt = 32'(own_r);
          gpc_pkg::OFS_OE_RD:    out_rdata_nxt = 32'(oe_r);
          gpc_pkg::OFS_FLT_RD:   out_rdata_nxt = 32'(flt_r);
          gpc_pkg::OFS_ODATA:    out_rdata_nxt = 32'(odata_r);
          gpc_pkg::OFS_PDATA_RD: out_rdata_nxt = 32'(pin_data_r);
          gpc_pkg::OFS_IMASK_RD: out_rdata_nxt = 32'(imask_r);
          gpc_pkg::OFS_ISTAT_RD: begin
            // Reading the status returns it and clears it.
            out_rdata_nxt = 32'(istat_r);
            istat_cleared = '0;
          end
          gpc_pkg::OFS_MD_RD:    out_rdata_nxt = 32'(md_r);
          gpc_pkg::OFS_PU_RD:    out_rdata_nxt = 32'(pu_dis_r);
          gpc_pkg::OFS_PB_RD:    out_rdata_nxt = 32'(pb_sel_r);
          gpc_pkg::OFS_WE_RD:    out_rdata_nxt = 32'(we_r);
          default:               out_bad_nxt   = 1'b1;
        endcase
      end
      gpc_pkg::CMD_WRITE: begin
        case (s0_ofs_r)
          gpc_pkg::OFS_OWN_SET:   own_nxt    = own_r | wdata;
          gpc_pkg::OFS_OWN_CLR:   own_nxt    = own_r & ~wdata;
          gpc_pkg::OFS_OE_SET:    oe_nxt     = oe_r | wdata;
          gpc_pkg::OFS_OE_CLR:    oe_nxt     = oe_r & ~wdata;
          gpc_pkg::OFS_FLT_SET:   flt_nxt    = flt_r | wdata;
          gpc_pkg::OFS_FLT_CLR:   flt_nxt    = flt_r & ~wdata;
          gpc_pkg::OFS_ODATA_SET: odata_nxt  = odata_r | wdata;
          gpc_pkg::OFS_ODATA_CLR: odata_nxt  = odata_r & ~wdata;
          // The direct write touches only the bits that write_enable allows.
          gpc_pkg::OFS_ODATA:     odata_nxt  = (odata_r & ~we_r) | (wdata & we_r);
          gpc_pkg::OFS_IMASK_SET: imask_nxt  = imask_r | wdata;
          gpc_pkg::OFS_IMASK_CLR: imask_nxt  = imask_r & ~wdata;
          gpc_pkg::OFS_MD_SET:    md_nxt     = md_r | wdata;
          gpc_pkg::OFS_MD_CLR:    md_nxt     = md_r & ~wdata;
          gpc_pkg::OFS_PU_DIS:    pu_dis_nxt = pu_dis_r | wdata;
          gpc_pkg::OFS_PU_EN:     pu_dis_nxt = pu_dis_r & ~wdata;
          gpc_pkg::OFS_PB_CLR:    pb_sel_nxt = pb_sel_r & ~wdata;
          gpc_pkg::OFS_PB_SET:    pb_sel_nxt = pb_sel_r | wdata;
          gpc_pkg::OFS_WE_SET:    we_nxt     = we_r | wdata;
          gpc_pkg::OFS_WE_CLR:    we_nxt     = we_r & ~wdata;
          default:                out_bad_nxt = 1'b1;
        endcase
        recompute = !out_bad_nxt;
      end
      gpc_pkg::CMD_PAD: begin
        if (pin_ok) begin
          pad_lvl_nxt = s0_level_r ? (pad_lvl_r | pin_bit) : (pad_lvl_r & ~pin_bit);
          recompute   = 1'b1;
        end
      end
      gpc_pkg::CMD_PER_A: begin
        if (pin_ok) begin
          pa_lvl_nxt = s0_level_r ? (pa_lvl_r | pin_bit) : (pa_lvl_r & ~pin_bit);
          recompute  = 1'b1;
        end
      end
      gpc_pkg::CMD_PER_B: begin
        if (pin_ok) begin
          pb_lvl_nxt = s0_level_r ? (pb_lvl_r | pin_bit) : (pb_lvl_r & ~pin_bit);
          recompute  = 1'b1;
        end
      end
      default: begin
        // Unused command codes change nothing.
      end
    endcase
  end

  // Pin multiplexer: owner selects output data, pad input or a peripheral line.
  always_comb begin
    own_levels   = own_nxt & ((oe_nxt & odata_nxt) | (~oe_nxt & pad_lvl_nxt));
    per_levels   = ~own_nxt & ((~pb_sel_nxt & pa_lvl_nxt) | (pb_sel_nxt & pb_lvl_nxt));
    pin_data_nxt = recompute ? (own_levels | per_levels) : pin_data_r;
    istat_nxt    = istat_cleared | (pin_data_r ^ pin_data_nxt);
    out_pad_nxt  = 32'(pin_data_nxt);
    out_irq_nxt  = |(istat_nxt & imask_nxt);
    out_chg_nxt  = pin_data_nxt != pin_data_r;
    is_stat_rd   = (s0_cmd_r == gpc_pkg::CMD_READ) && (s0_ofs_r == gpc_pkg::OFS_ISTAT_RD);
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s0_valid_r  <= s0_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_cmd_r   <= in_chan.cmd;
      s0_ofs_r   <= in_chan.word_offset;
      s0_wdata_r <= in_chan.write_data;
      s0_pin_r   <= in_chan.pin_index;
      s0_level_r <= in_chan.pin_level;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_rdata_r <= out_rdata_nxt;
      out_pad_r   <= out_pad_nxt;
      out_irq_r   <= out_irq_nxt;
      out_chg_r   <= out_chg_nxt;
      out_bad_r   <= out_bad_nxt;
    end
  end

  // Controller state advances with each beat that moves to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r      <= '0;
      oe_r       <= '0;
      flt_r      <= '0;
      odata_r    <= '0;
      pin_data_r <= '0;
      imask_r    <= '0;
      istat_r    <= '0;
      md_r       <= '0;
      pu_dis_r   <= '0;
      pb_sel_r   <= '0;
      we_r       <= '0;
      pad_lvl_r  <= '0;
      pa_lvl_r   <= '0;
      pb_lvl_r   <= '0;
    end else if (adv) begin
      own_r      <= own_nxt;
      oe_r       <= oe_nxt;
      flt_r      <= flt_nxt;
      odata_r    <= odata_nxt;
      pin_data_r <= pin_data_nxt;
      imask_r    <= imask_nxt;
      istat_r    <= istat_nxt;
      md_r       <= md_nxt;
      pu_dis_r   <= pu_dis_nxt;
      pb_sel_r   <= pb_sel_nxt;
      we_r       <= we_nxt;
      pad_lvl_r  <= pad_lvl_nxt;
      pa_lvl_r   <= pa_lvl_nxt;
      pb_lvl_r   <= pb_lvl_nxt;
    end
  end

  // Result channel outputs.
  assign out_chan.valid          = out_valid_r;
  assign out_chan.read_data      = out_rdata_r;
  assign out_chan.pad_levels     = out_pad_r;
  assign out_chan.irq_out        = out_irq_r;
  assign out_chan.levels_changed = out_chg_r;
  assign out_chan.bad_access     = out_bad_r;

  // An illegal access never changes pin levels.
  `GPC_ASSERT_NOW(a_bad_no_change, out_valid_r && out_bad_r, !out_chg_r)

  // The reported pin levels match the stored pin state after each beat.
  `GPC_ASSERT_NEXT(a_pad_matches_state, adv, out_pad_r == 32'(pin_data_r))

  // Only bus reads return nonzero data.
  `GPC_ASSERT_NEXT(a_rdata_only_on_read, adv && (s0_cmd_r != gpc_pkg::CMD_READ),
                   out_rdata_r == '0)

  // Interrupt status bits are lost only through a status read.
  `GPC_ASSERT_NEXT(a_istat_sticky, adv && !is_stat_rd,
                   (istat_r & $past(istat_r)) == $past(istat_r))

  // The interrupt line reflects status and mask after the beat.
  `GPC_ASSERT_NEXT(a_irq_matches_state, adv, out_irq_r == (|(istat_r & imask_r)))

endmodule

`default_nettype wire
